[hdl/ptss_pkg.sv]
// shared types and constants of the periodic task slot scheduler
package ptss_pkg;

  localparam int JOB_W  = 8;
  localparam int LEFT_W = 16;
  localparam int MS_W   = 32;

  localparam logic       ACT_TICK = 1'b0;
  localparam logic       ACT_ADD  = 1'b1;
  localparam logic       STAT_OK   = 1'b0;
  localparam logic       STAT_FULL = 1'b1;
  localparam logic signed [LEFT_W-1:0] RUNS_FOREVER = -16'sd1;
  localparam logic signed [LEFT_W-1:0] LEFT_MIN     = -16'sd32768;

  typedef struct packed {
    logic                     action;
    logic [MS_W-1:0]          now_ms;
    logic [MS_W-1:0]          period;
    logic signed [LEFT_W-1:0] runs;
    logic [JOB_W-1:0]         job_id;
  } in_item_t;

  typedef struct packed {
    logic [JOB_W-1:0] fired_id;
    logic             fired;
    logic             finished;
    logic             status;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic fire;
    logic gone;
  } eval_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } sched_state_t;

endpackage

[hdl/ptss_ram.sv]
// generic single write port ram with registered read
module ptss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/ptss_slot_eval.sv]
// due check and run count update of one slot
module ptss_slot_eval
  import ptss_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]     now,
  input  logic [TIME_BITS-1:0]     last_run,
  input  logic [TIME_BITS-1:0]     period,
  input  logic signed [LEFT_W-1:0] left,
  input  logic                     endless,
  output logic [TIME_BITS-1:0]     last_run_nxt,
  output logic signed [LEFT_W-1:0] left_nxt,
  output eval_flags_t              flags
);

  logic [TIME_BITS-1:0]   elapsed;
  logic                   fire;
  logic signed [LEFT_W:0] left_dec;

  always_comb begin
    elapsed      = now - last_run;
    fire         = (elapsed >= period);
    last_run_nxt = fire ? (last_run + period) : last_run;
    // one bit wider so the step below the minimum is seen
    left_dec     = {left[LEFT_W-1], left} - (LEFT_W+1)'(fire);
    if (endless) begin
      left_nxt = left;
    end else if (left_dec[LEFT_W] != left_dec[LEFT_W-1]) begin
      left_nxt = LEFT_MIN;
    end else begin
      left_nxt = left_dec[LEFT_W-1:0];
    end
    flags.fire = fire;
    flags.gone = !endless && (left_dec <= 0);
  end

endmodule

[hdl/periodic_task_slot_scheduler.sv]
// top level of the periodic task slot scheduler
//
// usage
//   items go in through start / busy / in_item: a transfer happens at a rising
//   edge with start high and busy low. action selects add or tick.
//   results leave on out_item, each shown for one cycle with out_strobe high;
//   the receiver cannot hold them off, so the block never waits for it.
//   out_item.last marks the final result of an item.
// add and tick
//   add: result in the cycle after the transfer, busy stays low.
//   tick: the slot table sits in one ram with registered read: each slot goes
//   through a read state and an evaluate/write-back state.
//   a firing result is held back until the next firing or the end of the
//   walk so that last can be set on the final one; the trailing result shows
//   in the cycle after the closing read, when busy is already low again.
// reset
//   rst_n is synchronous, active low; the table is emptied by clearing the
//   slot count only, the ram contents are not touched.
// removal keeps order: surviving slots are written back at a trailing index.
module periodic_task_slot_scheduler
  import ptss_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef struct packed {
    logic                     endless;
    logic signed [LEFT_W-1:0] left;
    logic [TIME_BITS-1:0]     last_run;
    logic [TIME_BITS-1:0]     period;
    logic [JOB_W-1:0]         job;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  sched_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;   // slot being walked
  logic [CNT_W-1:0]     wr_idx_r, wr_idx_nxt;   // compaction target
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 pend_v_r, pend_v_nxt;
  out_item_t            pend_r, pend_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_item_t            out_item_r, out_item_nxt;

  // ram side
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  slot_t                ram_wslot;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SLOT_W-1:0]    ram_rdata;
  slot_t                cur_slot;

  // evaluation of the slot just read
  logic [TIME_BITS-1:0]     ev_last_run;
  logic signed [LEFT_W-1:0] ev_left;
  eval_flags_t              ev_flags;

  assign cur_slot = slot_t'(ram_rdata);

  ptss_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (SLOT_W'(ram_wslot)),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ptss_slot_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .now          (now_r),
    .last_run     (cur_slot.last_run),
    .period       (cur_slot.period),
    .left         (cur_slot.left),
    .endless      (cur_slot.endless),
    .last_run_nxt (ev_last_run),
    .left_nxt     (ev_left),
    .flags        (ev_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    now_r      <= now_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    now_nxt        = now_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;

    ram_we         = 1'b0;
    ram_waddr      = used_r[IDX_W-1:0];
    ram_raddr      = rd_idx_r[IDX_W-1:0];

    ram_wslot.job      = in_item.job_id;
    ram_wslot.period   = TIME_BITS'(in_item.period);
    ram_wslot.last_run = TIME_BITS'(in_item.now_ms);
    ram_wslot.left     = in_item.runs;
    ram_wslot.endless  = (in_item.runs == RUNS_FOREVER);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.action == ACT_ADD) begin
            out_strobe_nxt        = 1'b1;
            out_item_nxt          = '0;
            out_item_nxt.last     = 1'b1;
            if (used_r == CNT_W'(SLOT_COUNT)) begin
              out_item_nxt.status = STAT_FULL;
            end else begin
              out_item_nxt.status = STAT_OK;
              ram_we              = 1'b1;
              used_nxt            = used_r + 1'b1;
            end
          end else begin
            now_nxt    = TIME_BITS'(in_item.now_ms);
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (rd_idx_r == used_r) begin
          // end of walk: release the held firing or an empty result
          out_strobe_nxt = 1'b1;
          if (pend_v_r) begin
            out_item_nxt = pend_r;
          end else begin
            out_item_nxt = '0;
          end
          out_item_nxt.last = 1'b1;
          pend_v_nxt        = 1'b0;
          used_nxt          = wr_idx_r;
          state_nxt         = ST_IDLE;
        end else begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        ram_waddr          = wr_idx_r[IDX_W-1:0];
        ram_wslot          = cur_slot;
        ram_wslot.last_run = ev_last_run;
        ram_wslot.left     = ev_left;
        ram_we             = !ev_flags.gone;
        if (!ev_flags.gone) begin
          wr_idx_nxt = wr_idx_r + 1'b1;
        end
        if (ev_flags.fire) begin
          if (pend_v_r) begin
            out_strobe_nxt    = 1'b1;
            out_item_nxt      = pend_r;
            out_item_nxt.last = 1'b0;
          end
          pend_v_nxt        = 1'b1;
          pend_nxt.fired_id = cur_slot.job;
          pend_nxt.fired    = 1'b1;
          pend_nxt.finished = ev_flags.gone;
          pend_nxt.status   = STAT_OK;
          pend_nxt.last     = 1'b0;
        end
        rd_idx_nxt = rd_idx_r + 1'b1;
        state_nxt  = ST_READ;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[tb/tb_periodic_task_slot_scheduler.sv]
// self-checking testbench of the periodic task slot scheduler: table-driven and random transfers
module tb_periodic_task_slot_scheduler
  import ptss_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = 8;
  localparam int RAND_ITEMS = 150;
  localparam int QUIET_FROM = 125;   // no idling from this random item onwards
  localparam int PAUSE_AT   = 85;    // sender waits for every result here
  localparam int TAIL_WAIT  = 40;    // longer than a tick walk over a full table

  // add accepted and an idle tick look the same; a full table differs in status only
  localparam out_item_t RES_IDLE = '{fired_id: '0, fired: 1'b0, finished: 1'b0,
                                     status: STAT_OK, last: 1'b1};
  localparam out_item_t RES_FULL = '{fired_id: '0, fired: 1'b0, finished: 1'b0,
                                     status: STAT_FULL, last: 1'b1};

  typedef struct {
    in_item_t  item;
    bit        typed;   // row carries a hand-written result
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // row attributes that travel with the item being offered
  bit        row_typed;
  out_item_t row_want;

  stim_row_t stim_rows[$];
  out_item_t pending_results[$];   // results still owed by the block, oldest first
  out_item_t item_results[$];      // results of the item just predicted
  int        fail_count;

  // shadow slot table, kept in insertion order
  logic [JOB_W-1:0]         tab_job[SLOT_COUNT];
  logic [MS_W-1:0]          tab_period[SLOT_COUNT];
  logic [MS_W-1:0]          tab_last[SLOT_COUNT];
  logic signed [LEFT_W-1:0] tab_left[SLOT_COUNT];
  logic                     tab_forever[SLOT_COUNT];
  int                       tab_used;

  periodic_task_slot_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // one add or tick applied to the shadow table; results land in item_results
  function automatic void schedule_step(input in_item_t it);
    int          idx;
    int          left_next;
    logic [31:0] elapsed;
    logic        fire;
    logic        gone;
    out_item_t   res;
    item_results.delete();
    if (it.action == ACT_ADD) begin
      if (tab_used >= SLOT_COUNT) begin
        // table full: the add is dropped
        item_results.push_back(RES_FULL);
      end else begin
        tab_job[tab_used]     = it.job_id;
        tab_period[tab_used]  = it.period;
        tab_last[tab_used]    = it.now_ms;
        tab_left[tab_used]    = it.runs;
        tab_forever[tab_used] = (it.runs == RUNS_FOREVER);
        tab_used++;
        item_results.push_back(RES_IDLE);
      end
      return;
    end
    idx = 0;
    while (idx < tab_used) begin
      // elapsed time wraps at 32 bits
      elapsed = it.now_ms - tab_last[idx];
      fire    = (elapsed >= tab_period[idx]);
      gone    = 1'b0;
      if (fire) begin
        // advance by one period only, so a late tick catches up gradually
        tab_last[idx] = tab_last[idx] + tab_period[idx];
      end
      if (!tab_forever[idx]) begin
        left_next     = int'(tab_left[idx]) - (fire ? 1 : 0);
        tab_left[idx] = (left_next < -32768) ? LEFT_MIN : LEFT_W'(left_next);
        // a non-positive count drops the slot even without a firing
        gone          = (left_next <= 0);
      end
      if (fire) begin
        res = '{fired_id: tab_job[idx], fired: 1'b1, finished: gone,
                status: STAT_OK, last: 1'b0};
        item_results.push_back(res);
      end
      if (gone) begin
        // compact the table, order of the survivors kept
        for (int k = idx; k < tab_used - 1; k++) begin
          tab_job[k]     = tab_job[k+1];
          tab_period[k]  = tab_period[k+1];
          tab_last[k]    = tab_last[k+1];
          tab_left[k]    = tab_left[k+1];
          tab_forever[k] = tab_forever[k+1];
        end
        tab_used--;
      end else begin
        idx++;
      end
    end
    if (item_results.size() == 0) begin
      item_results.push_back(RES_IDLE);
    end else begin
      item_results[item_results.size()-1].last = 1'b1;
    end
  endfunction

  // slots that will stay for a long time; the random part keeps these few
  function automatic int lasting_slots();
    int n;
    n = 0;
    for (int k = 0; k < tab_used; k++) begin
      if (tab_forever[k] || tab_left[k] > 40 || tab_period[k] > 5000) n++;
    end
    return n;
  endfunction

  task automatic put_row(input logic act, input logic [MS_W-1:0] now,
                         input logic [MS_W-1:0] per, input logic signed [LEFT_W-1:0] runs,
                         input logic [JOB_W-1:0] job, input bit typed, input out_item_t want);
    stim_row_t row;
    row.item  = '{action: act, now_ms: now, period: per, runs: runs, job_id: job};
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  // offer one item from a falling edge and return at the falling edge after its transfer;
  // start is written once per falling edge, so a back-to-back item keeps it high
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want,
                            input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item   = it;
    row_typed = typed;
    row_want  = want;
    start     = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // result checker and transfer monitor, all on the rising edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      // results of an item transferred on this edge cannot appear before the next one
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual id=%0h fired=%0b fin=%0b st=%0b last=%0b",
                   $time, out_item.fired_id, out_item.fired, out_item.finished,
                   out_item.status, out_item.last);
        end else begin
          want = pending_results.pop_front();
          if (out_item.fired_id !== want.fired_id || out_item.fired !== want.fired ||
              out_item.finished !== want.finished || out_item.status !== want.status ||
              out_item.last !== want.last) begin
            fail_count++;
            $display("%0t: mismatch expected id=%0h fired=%0b fin=%0b st=%0b last=%0b",
                     $time, want.fired_id, want.fired, want.finished, want.status, want.last);
            $display("%0t:          actual   id=%0h fired=%0b fin=%0b st=%0b last=%0b",
                     $time, out_item.fired_id, out_item.fired, out_item.finished,
                     out_item.status, out_item.last);
          end
        end
      end
      if (start && !busy) begin
        // the shadow table always moves on, even where the row gives its own result
        schedule_step(in_item);
        if (row_typed) begin
          pending_results.push_back(row_want);
        end else begin
          foreach (item_results[k]) pending_results.push_back(item_results[k]);
        end
      end
    end
  end

  // stimulus
  initial begin
    in_item_t    it;
    logic [31:0] cur_ms;
    int          pick;
    int          gap;
    start      = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    row_typed  = 1'b0;
    row_want   = RES_IDLE;
    fail_count = 0;
    tab_used   = 0;

    // directed table: an empty tick, adds up to a full table, then ticks over every slot kind with adds mixed in
    put_row(ACT_TICK, 32'd0, 32'd0, 16'sd0, 8'h00, 1'b1, RES_IDLE);          // empty table
    put_row(ACT_ADD, 32'd0, 32'd10, RUNS_FOREVER, 8'h11, 1'b1, RES_IDLE);    // forever slot
    put_row(ACT_ADD, 32'd0, 32'd0, 16'sd2, 8'hFF, 1'b1, RES_IDLE);           // zero period
    put_row(ACT_ADD, 32'd0, 32'hFFFF_FFFF, 16'sd1, 8'h00, 1'b1, RES_IDLE);   // widest period
    put_row(ACT_ADD, 32'd0, 32'd5, 16'sd0, 8'h5A, 1'b1, RES_IDLE);           // count zero
    put_row(ACT_ADD, 32'd0, 32'd100, LEFT_MIN, 8'hA5, 1'b1, RES_IDLE);       // most negative
    put_row(ACT_ADD, 32'd0, 32'd1, 16'sd32767, 8'h3C, 1'b1, RES_IDLE);       // largest count
    put_row(ACT_ADD, 32'd0, 32'd7, -16'sd2, 8'hC3, 1'b1, RES_IDLE);          // negative count
    put_row(ACT_ADD, 32'd0, 32'd2, 16'sd3, 8'h81, 1'b1, RES_IDLE);           // eighth slot
    put_row(ACT_ADD, 32'd0, 32'd9, 16'sd1, 8'h42, 1'b1, RES_FULL);           // table full
    put_row(ACT_TICK, 32'd3, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);          // silent removals
    put_row(ACT_ADD, 32'd3, 32'd4, 16'sd1, 8'h7E, 1'b1, RES_IDLE);
    put_row(ACT_TICK, 32'd10, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);
    put_row(ACT_TICK, 32'd10, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);
    put_row(ACT_TICK, 32'd1000, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);       // late tick
    put_row(ACT_TICK, 32'd1000, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);       // catching up
    put_row(ACT_TICK, 32'hFFFF_FFFF, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);  // top of time
    put_row(ACT_ADD, 32'hFFFF_FFF0, 32'h20, 16'sd1, 8'h96, 1'b1, RES_IDLE);
    put_row(ACT_TICK, 32'h10, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);         // across the wrap
    put_row(ACT_TICK, 32'h10, 32'd0, 16'sd0, 8'h00, 1'b0, RES_IDLE);

    // reset held from the start, released on a falling edge
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[r]) begin
      gap = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 14) : 0;
      offer_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want, gap);
    end

    // random part: mostly a steadily running clock with adds mixed in, some jumps
    cur_ms = 32'd20;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        // hold off until the block has delivered everything
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      it   = '0;
      pick = $urandom_range(0, 99);
      if ((tab_used < SLOT_COUNT && pick < 35) || pick < 8) begin
        it.action = ACT_ADD;
        it.now_ms = cur_ms;
        it.job_id = JOB_W'($urandom);
        it.period = ($urandom_range(0, 9) == 0 && lasting_slots() < 3) ?
                    $urandom : $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        if (pick < 15 && lasting_slots() < 3) begin
          it.runs = RUNS_FOREVER;
        end else if (pick < 27) begin
          // negative counts other than forever leave at the first tick
          it.runs = LEFT_W'($urandom_range(16'h8000, 16'hFFFE));
        end else if (pick < 33 && lasting_slots() < 3) begin
          it.runs = LEFT_W'($urandom_range(16'h4000, 16'h7FFF));
        end else begin
          it.runs = LEFT_W'($urandom_range(0, 6));
        end
      end else begin
        it.action = ACT_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          cur_ms = cur_ms + $urandom_range(0, 12);
        end else if (pick < 90) begin
          cur_ms = cur_ms + $urandom_range(13, 3000);
        end else begin
          cur_ms = $urandom;   // time jump, any bit pattern
        end
        it.now_ms = cur_ms;
        // idle fields of a tick carry noise
        it.period = $urandom;
        it.runs   = LEFT_W'($urandom);
        it.job_id = JOB_W'($urandom);
      end
      gap = (n < QUIET_FROM && $urandom_range(0, 9) < 3) ? $urandom_range(1, 14) : 0;
      offer_item(it, 1'b0, RES_IDLE, gap);
    end

    // drain, then let the last walk close
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
